// ----- rtl/bq_pkg.sv -----
// shared constants, types and saturation helpers for the biquad filter
`timescale 1ns / 1ps
`default_nettype none

package bq_pkg;

    localparam int SAMPLE_WIDTH   = 16;
    localparam int COEF_WIDTH     = 24;
    localparam int COEF_FRAC_BITS = 20;
    localparam int DELAY_WIDTH    = SAMPLE_WIDTH + 28;
    localparam int PROD_WIDTH     = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int ACC_WIDTH      = DELAY_WIDTH + 2;
    localparam int CFG_IDX_WIDTH  = 3;

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;
    typedef logic signed [COEF_WIDTH-1:0]   t_coef;
    typedef logic signed [DELAY_WIDTH-1:0]  t_delay;
    typedef logic signed [PROD_WIDTH-1:0]   t_prod;
    typedef logic signed [ACC_WIDTH-1:0]    t_acc;
    typedef logic [CFG_IDX_WIDTH-1:0]       t_cfg_idx;

    // register indexes
    localparam t_cfg_idx REG_FF_COEF_0 = t_cfg_idx'(0);
    localparam t_cfg_idx REG_FF_COEF_1 = t_cfg_idx'(1);
    localparam t_cfg_idx REG_FF_COEF_2 = t_cfg_idx'(2);
    localparam t_cfg_idx REG_FB_COEF_1 = t_cfg_idx'(3);
    localparam t_cfg_idx REG_FB_COEF_2 = t_cfg_idx'(4);

    // unity gain in q4.20
    localparam t_coef COEF_ONE = t_coef'(1) <<< COEF_FRAC_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_A0,
        S_MUL_A1,
        S_MUL_A2,
        S_MUL_B1,
        S_MUL_B2,
        S_FINISH
    } t_state;

    typedef enum logic [2:0] {
        MUL_X_A0,
        MUL_X_A1,
        MUL_X_A2,
        MUL_Y_B1,
        MUL_Y_B2
    } t_mul_sel;

    typedef struct packed {
        logic     load_x;
        t_mul_sel mul_sel;
        logic     y_load;
        logic     acc1_init;
        logic     acc2_init;
        logic     acc1_sub;
        logic     commit;
    } t_dp_ctrl;

    function automatic t_sample sat_sample(input t_acc v);
        logic upper_same;
        begin
            upper_same = (v[ACC_WIDTH-1:SAMPLE_WIDTH-1] == '0) ||
                         (v[ACC_WIDTH-1:SAMPLE_WIDTH-1] == '1);
            if (upper_same) begin
                sat_sample = v[SAMPLE_WIDTH-1:0];
            end else if (v[ACC_WIDTH-1]) begin
                sat_sample = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
            end else begin
                sat_sample = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
            end
        end
    endfunction

    function automatic t_delay sat_delay(input t_acc v);
        logic upper_same;
        begin
            upper_same = (v[ACC_WIDTH-1:DELAY_WIDTH-1] == '0) ||
                         (v[ACC_WIDTH-1:DELAY_WIDTH-1] == '1);
            if (upper_same) begin
                sat_delay = v[DELAY_WIDTH-1:0];
            end else if (v[ACC_WIDTH-1]) begin
                sat_delay = {1'b1, {(DELAY_WIDTH-1){1'b0}}};
            end else begin
                sat_delay = {1'b0, {(DELAY_WIDTH-1){1'b1}}};
            end
        end
    endfunction

endpackage

`default_nettype wire

// ----- rtl/bq_datapath.sv -----
// coefficient registers, shared multiplier, accumulators and delay state
`timescale 1ns / 1ps
`default_nettype none

module bq_datapath (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire bq_pkg::t_cfg_idx i_cfg_index,
    input  wire bq_pkg::t_coef    i_cfg_data,
    input  wire bq_pkg::t_sample  i_sample,
    input  wire bq_pkg::t_dp_ctrl i_ctrl,
    output bq_pkg::t_sample       o_y
);
    import bq_pkg::*;

    t_coef   r_ff0, r_ff1, r_ff2, r_fb1, r_fb2;
    t_sample r_x;
    t_sample r_y;
    t_prod   r_prod;
    t_acc    r_acc1;
    t_acc    r_acc2;
    t_delay  r_d1;
    t_delay  r_d2;

    t_sample mul_a;
    t_coef   mul_b;
    t_prod   prod;
    t_acc    y_sum;
    t_acc    y_shift;
    t_acc    n2_sum;

    // coefficient writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ff0 <= COEF_ONE;
            r_ff1 <= '0;
            r_ff2 <= '0;
            r_fb1 <= '0;
            r_fb2 <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FF_COEF_0: r_ff0 <= i_cfg_data;
                REG_FF_COEF_1: r_ff1 <= i_cfg_data;
                REG_FF_COEF_2: r_ff2 <= i_cfg_data;
                REG_FB_COEF_1: r_fb1 <= i_cfg_data;
                REG_FB_COEF_2: r_fb2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // shared multiplier operand select
    always_comb begin
        case (i_ctrl.mul_sel)
            MUL_X_A0: begin mul_a = r_x; mul_b = r_ff0; end
            MUL_X_A1: begin mul_a = r_x; mul_b = r_ff1; end
            MUL_X_A2: begin mul_a = r_x; mul_b = r_ff2; end
            MUL_Y_B1: begin mul_a = r_y; mul_b = r_fb1; end
            MUL_Y_B2: begin mul_a = r_y; mul_b = r_fb2; end
            default:  begin mul_a = r_x; mul_b = r_ff0; end
        endcase
    end

    assign prod = mul_a * mul_b;

    // round half up, then shift to sample scale
    assign y_sum   = t_acc'(r_prod) + t_acc'(r_d1) + (t_acc'(1) <<< (COEF_FRAC_BITS - 1));
    assign y_shift = y_sum >>> COEF_FRAC_BITS;
    assign n2_sum  = r_acc2 - t_acc'(r_prod);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_x) begin
            r_x <= i_sample;
        end
        r_prod <= prod;
        if (i_ctrl.y_load) begin
            r_y <= sat_sample(y_shift);
        end
        if (i_ctrl.acc1_init) begin
            r_acc1 <= t_acc'(r_prod) + t_acc'(r_d2);
        end else if (i_ctrl.acc1_sub) begin
            r_acc1 <= r_acc1 - t_acc'(r_prod);
        end
        if (i_ctrl.acc2_init) begin
            r_acc2 <= t_acc'(r_prod);
        end
    end

    // delay state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1 <= '0;
            r_d2 <= '0;
        end else if (i_ctrl.commit) begin
            r_d1 <= sat_delay(r_acc1);
            r_d2 <= sat_delay(n2_sum);
        end
    end

    assign o_y = r_y;

endmodule

`default_nettype wire

// ----- rtl/biquad_iir_filter.sv -----
// biquad iir filter top level: sequencer, handshakes and output register
`timescale 1ns / 1ps
`default_nettype none

// Second-order IIR filter in transposed direct form II. One signed 16-bit
// sample in, one saturated 16-bit sample out per item. All five products go
// through a single 16x24 multiplier in turn, so an item passes an accept
// state, a multiplier state for each product and a finish state that updates
// the delay state and loads the output register before the next item can be
// accepted. The input is stalled while an item is in work. A finished
// result waits in the output register and does not hold off the next item,
// but that item cannot finish, and the one after it cannot be accepted, until
// the output register is free.
// Coefficients are signed Q4.20 and reset to a pass-through; write them only
// while the filter is idle.
module biquad_iir_filter (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire bq_pkg::t_cfg_idx i_cfg_index,
    input  wire bq_pkg::t_coef    i_cfg_data,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire bq_pkg::t_sample  i_sample_in,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output bq_pkg::t_sample       o_sample_out
);
    import bq_pkg::*;

    t_state   r_state, n_state;
    t_dp_ctrl ctrl;
    t_sample  y;
    logic     r_out_valid;
    t_sample  r_sample_out;
    logic     out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        ctrl.load_x    = 1'b0;
        ctrl.mul_sel   = MUL_X_A0;
        ctrl.y_load    = 1'b0;
        ctrl.acc1_init = 1'b0;
        ctrl.acc2_init = 1'b0;
        ctrl.acc1_sub  = 1'b0;
        ctrl.commit    = 1'b0;
        o_in_stall     = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    ctrl.load_x = 1'b1;
                    n_state     = S_MUL_A0;
                end
            end
            S_MUL_A0: begin
                ctrl.mul_sel = MUL_X_A0;
                n_state      = S_MUL_A1;
            end
            S_MUL_A1: begin
                ctrl.mul_sel = MUL_X_A1;
                ctrl.y_load  = 1'b1;
                n_state      = S_MUL_A2;
            end
            S_MUL_A2: begin
                ctrl.mul_sel   = MUL_X_A2;
                ctrl.acc1_init = 1'b1;
                n_state        = S_MUL_B1;
            end
            S_MUL_B1: begin
                ctrl.mul_sel   = MUL_Y_B1;
                ctrl.acc2_init = 1'b1;
                n_state        = S_MUL_B2;
            end
            S_MUL_B2: begin
                ctrl.mul_sel  = MUL_Y_B2;
                ctrl.acc1_sub = 1'b1;
                n_state       = S_FINISH;
            end
            S_FINISH: begin
                // hold the last product until the output register is free
                ctrl.mul_sel = MUL_Y_B2;
                if (out_free) begin
                    ctrl.commit = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    bq_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_sample    (i_sample_in),
        .i_ctrl      (ctrl),
        .o_y         (y)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.commit) begin
            r_sample_out <= y;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_sample_out;

endmodule

`default_nettype wire
